// File: rtl/core/xtea_pkg.sv
// Shared constants, types and stage helper functions for the XTEA encipher block.
package xtea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CYC_W      = 7;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned ROUNDS_MIN = 1;
  localparam int unsigned ROUNDS_MAX = 64;
  // Two half-round stages per XTEA cycle.
  localparam int unsigned NUM_STAGES = 2 * ROUNDS_MAX;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

  localparam logic [CYC_W-1:0]  RESET_CYCLES = 7'd32;
  localparam logic [WORD_W-1:0] RESET_KEY0   = 32'd18748274;
  localparam logic [WORD_W-1:0] RESET_KEY1   = 32'd228374;
  localparam logic [WORD_W-1:0] RESET_KEY2   = 32'd193034845;
  localparam logic [WORD_W-1:0] RESET_KEY3   = 32'd85726348;

  typedef enum logic [IDX_W-1:0] {
    REG_ROUND_COUNT = 3'd0,
    REG_KEY_WORD0   = 3'd1,
    REG_KEY_WORD1   = 3'd2,
    REG_KEY_WORD2   = 3'd3,
    REG_KEY_WORD3   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CYC_W-1:0]             cycles;
    logic [3:0][WORD_W-1:0]       key;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic active;
  } stage_ctl_t;

  // Running sum seen by half-round h: the first half of cycle c uses c*delta,
  // the second half uses (c+1)*delta.
  function automatic logic [WORD_W-1:0] stage_sum(input int unsigned h);
    logic [63:0] cnt;
    logic [63:0] prod;
    cnt  = 64'(h / 2) + 64'(h % 2);
    prod = cnt * {32'b0, DELTA};
    return prod[WORD_W-1:0];
  endfunction

  function automatic logic [1:0] stage_key_idx(input int unsigned h);
    logic [WORD_W-1:0] s;
    s = stage_sum(h);
    return (h % 2 == 0) ? s[1:0] : s[12:11];
  endfunction

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

// File: rtl/core/xtea_in_if.sv
// Plaintext input channel.
interface xtea_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_word;
  logic [31:0] second_word;

  modport source (output valid, output first_word, output second_word, input ready);
  modport sink   (input valid, input first_word, input second_word, output ready);
endinterface

// File: rtl/core/xtea_out_if.sv
// Ciphertext result channel.
interface xtea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_first;
  logic [31:0] cipher_second;

  modport source (output valid, output cipher_first, output cipher_second, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

// File: rtl/core/xtea_cfg_if.sv
// Configuration write channel.
interface xtea_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/xtea_block_encipher.sv
// XTEA encipher top level: configuration registers and the half-round pipeline.
// A 128-stage pipeline, one registered half-round per stage, enciphers one
// 64-bit block per clock at full rate; every block passes through each stage
// of the pipeline whatever the round count, since stages beyond the configured
// count pass the words through. The round count (1 to 64, saturated on write)
// and the four key words may be written only while no block is in flight.
// The whole pipeline holds when the result register is full and not taken,
// so in_blk.ready follows out_blk.ready combinationally.
module xtea_block_encipher (
  input  logic          clk,
  input  logic          rst_n,
  xtea_in_if.sink       in_blk,
  xtea_out_if.source    out_blk,
  xtea_cfg_if.sink      cfg_wr
);

  localparam int unsigned NS = xtea_pkg::NUM_STAGES;

  xtea_pkg::cfg_t              cfg;
  logic [NS:0]                 vld;
  logic [xtea_pkg::WORD_W-1:0] lft [NS+1];
  logic [xtea_pkg::WORD_W-1:0] rgt [NS+1];
  logic                        advance;

  xtea_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  assign advance      = !vld[NS] || out_blk.ready;
  assign in_blk.ready = advance;

  assign vld[0] = in_blk.valid;
  assign lft[0] = in_blk.first_word;
  assign rgt[0] = in_blk.second_word;

  for (genvar h = 0; h < NS; h++) begin : g_stage
    localparam logic [xtea_pkg::WORD_W-1:0] SUM_C = xtea_pkg::stage_sum(h);
    localparam logic [1:0]                  KIX   = xtea_pkg::stage_key_idx(h);
    localparam logic [xtea_pkg::CYC_W-1:0]  CYC   = 7'(h / 2);

    xtea_pkg::stage_ctl_t ctl;
    assign ctl.valid  = vld[h];
    assign ctl.active = (CYC < cfg.cycles);

    if (h % 2 == 0) begin : g_left
      xtea_stage u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl       (ctl),
        .sum_c     (SUM_C),
        .key       (cfg.key[KIX]),
        .upd_in    (lft[h]),
        .oth_in    (rgt[h]),
        .valid_out (vld[h+1]),
        .upd_out   (lft[h+1]),
        .oth_out   (rgt[h+1])
      );
    end else begin : g_right
      xtea_stage u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl       (ctl),
        .sum_c     (SUM_C),
        .key       (cfg.key[KIX]),
        .upd_in    (rgt[h]),
        .oth_in    (lft[h]),
        .valid_out (vld[h+1]),
        .upd_out   (rgt[h+1]),
        .oth_out   (lft[h+1])
      );
    end
  end

  assign out_blk.valid         = vld[NS];
  assign out_blk.cipher_first  = lft[NS];
  assign out_blk.cipher_second = rgt[NS];

  // The stored cycle count never leaves its legal range.
  a_cycles_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg.cycles >= 7'(xtea_pkg::ROUNDS_MIN)) && (cfg.cycles <= 7'(xtea_pkg::ROUNDS_MAX)))
    else $error("cycle count out of range");

  // A held pipeline neither drops nor creates beats in any stage.
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(vld[NS:1]))
    else $error("pipeline valid bits moved during a stall");

  // An accepted beat lands in the first stage on the next edge.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_blk.valid && in_blk.ready) |=> vld[1])
    else $error("accepted beat missing from first stage");

  // When the pipe advances, each stage takes the valid bit of its predecessor.
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (vld[NS:1] == $past(vld[NS-1:0])))
    else $error("valid bits did not shift with the pipeline");

endmodule

// File: rtl/core/xtea_cfg_regs.sv
// Configuration register file: round count (saturated on write) and key words.
module xtea_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  xtea_cfg_if.sink            cfg_wr,
  output xtea_pkg::cfg_t      cfg
);

  xtea_pkg::cfg_t cfg_r, cfg_nxt;
  logic [xtea_pkg::CYC_W-1:0] wr_cycles;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    if (cfg_wr.data[6:0] < 7'(xtea_pkg::ROUNDS_MIN)) begin
      wr_cycles = 7'(xtea_pkg::ROUNDS_MIN);
    end else if (cfg_wr.data[6:0] > 7'(xtea_pkg::ROUNDS_MAX)) begin
      wr_cycles = 7'(xtea_pkg::ROUNDS_MAX);
    end else begin
      wr_cycles = cfg_wr.data[6:0];
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        xtea_pkg::REG_ROUND_COUNT: cfg_nxt.cycles = wr_cycles;
        xtea_pkg::REG_KEY_WORD0:   cfg_nxt.key[0] = cfg_wr.data;
        xtea_pkg::REG_KEY_WORD1:   cfg_nxt.key[1] = cfg_wr.data;
        xtea_pkg::REG_KEY_WORD2:   cfg_nxt.key[2] = cfg_wr.data;
        xtea_pkg::REG_KEY_WORD3:   cfg_nxt.key[3] = cfg_wr.data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycles <= xtea_pkg::RESET_CYCLES;
      cfg_r.key[0] <= xtea_pkg::RESET_KEY0;
      cfg_r.key[1] <= xtea_pkg::RESET_KEY1;
      cfg_r.key[2] <= xtea_pkg::RESET_KEY2;
      cfg_r.key[3] <= xtea_pkg::RESET_KEY3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/xtea_stage.sv
// One registered XTEA half-round: updates one word from the other word.
module xtea_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  xtea_pkg::stage_ctl_t         ctl,
  input  logic [xtea_pkg::WORD_W-1:0]  sum_c,
  input  logic [xtea_pkg::WORD_W-1:0]  key,
  input  logic [xtea_pkg::WORD_W-1:0]  upd_in,
  input  logic [xtea_pkg::WORD_W-1:0]  oth_in,
  output logic                         valid_out,
  output logic [xtea_pkg::WORD_W-1:0]  upd_out,
  output logic [xtea_pkg::WORD_W-1:0]  oth_out
);

  logic                        valid_r;
  logic [xtea_pkg::WORD_W-1:0] upd_r, upd_nxt;
  logic [xtea_pkg::WORD_W-1:0] oth_r;
  logic [xtea_pkg::WORD_W-1:0] round_val;

  // Stages past the configured cycle count pass the word through unchanged.
  always_comb begin
    round_val = xtea_pkg::mix_word(oth_in) ^ (sum_c + key);
    upd_nxt   = ctl.active ? (upd_in + round_val) : upd_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      upd_r <= upd_nxt;
      oth_r <= oth_in;
    end
  end

  assign valid_out = valid_r;
  assign upd_out   = upd_r;
  assign oth_out   = oth_r;

endmodule
